>>> rtl/core/bha_pkg.sv
// Package for the block heap allocator: transaction structs, command and
// status codes, sequencer states and shared widths.
// Depends on nothing; every other file in rtl/core imports it.
package bha_pkg;

   localparam int HEAP_BLOCKS_DEF = 64;
   localparam int BLOCK_BYTES_DEF = 32;
   localparam int HEAP_BASE_DEF   = 4096;

   localparam int ADDR_W    = 16;
   localparam int BYTES_W   = 12;
   localparam int BYTES_MAX = 4095;
   localparam int ENTRY_W   = 8;
   localparam int LEN_W     = 7;
   localparam int WALK_W    = 8;
   localparam int DIV_W     = 17;

   typedef enum logic [1:0] {
      CMD_ALLOC,
      CMD_FREE,
      CMD_QUERY,
      CMD_NONE
   } command_type;

   typedef enum logic [2:0] {
      ST_OK,
      ST_ZERO_SIZE,
      ST_NO_FIT,
      ST_BAD_ADDR,
      ST_NOT_HEAD
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DIV_NEED,
      S_DIV_ALIGN,
      S_DIV_INDEX,
      S_WALK_RD,
      S_WALK_CHK,
      S_SPLIT,
      S_MARK,
      S_FREE_RD,
      S_FREE_CHK,
      S_CLEAR,
      S_RIGHT_RD,
      S_RIGHT_CHK,
      S_RIGHT_WR,
      S_LEFT_RD,
      S_LEFT_CHK,
      S_LEFT_WR,
      S_RESP
   } state_type;

   typedef struct packed {
      command_type        command;
      logic [ADDR_W-1:0]  request_bytes;
      logic [ADDR_W-1:0]  release_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  granted_address;
      status_type         status;
      logic [BYTES_W-1:0] total_free_bytes;
      logic [BYTES_W-1:0] largest_free_bytes;
   } rsp_type;

   typedef struct packed {
      logic               start;
      logic [DIV_W-1:0]   dividend;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic               rem_zero;
      logic [DIV_W-1:0]   quotient;
   } div_rsp_type;

endpackage

>>> rtl/core/bha_mem.sv
// Region table storage: one synchronous memory with a registered read port.
// Depends on bha_pkg; entries not yet written read as their reset value.
module bha_mem #(
   parameter int HEAP_BLOCKS = bha_pkg::HEAP_BLOCKS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rd_en,
   input  logic [$clog2(HEAP_BLOCKS)-1:0] rd_addr,
   output logic [bha_pkg::ENTRY_W-1:0]    rd_data,
   input  logic                           wr_en,
   input  logic [$clog2(HEAP_BLOCKS)-1:0] wr_addr,
   input  logic [bha_pkg::ENTRY_W-1:0]    wr_data
);
   import bha_pkg::*;

   localparam logic [ENTRY_W-1:0] HEAD_VALUE = ENTRY_W'(HEAP_BLOCKS);

   logic [ENTRY_W-1:0]     mem [HEAP_BLOCKS];
   logic [HEAP_BLOCKS-1:0] valid_ff;
   logic [ENTRY_W-1:0]     data_ff;
   logic                   vld_ff;
   logic                   zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_ff <= mem[rd_addr];
         vld_ff  <= valid_ff[rd_addr];
         zero_ff <= (rd_addr == '0);
      end
   end

   // An entry never written since reset holds the initial table contents.
   assign rd_data = vld_ff ? data_ff : (zero_ff ? HEAD_VALUE : '0);

endmodule

>>> rtl/core/bha_div.sv
// Divider by the constant block size: multiplication by a precomputed reciprocal
// and an exact remainder test, pipelined so that done follows start through stage0 and stage1.
// Depends on bha_pkg for the request and result structs.
module bha_div #(
   parameter int BLOCK_BYTES = bha_pkg::BLOCK_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bha_pkg::div_req_type div_req,
   output bha_pkg::div_rsp_type div_rsp
);
   import bha_pkg::*;

   // The reciprocal is rounded up with enough fraction bits to be exact for any dividend.
   localparam int              SHIFT   = DIV_W + $clog2(BLOCK_BYTES);
   localparam longint          RECIP_L = ((longint'(1) << SHIFT) + BLOCK_BYTES - 1)
                                         / BLOCK_BYTES;
   localparam logic [DIV_W:0]  RECIP   = (DIV_W + 1)'(RECIP_L);
   localparam int              PROD_W  = 2 * DIV_W + 1;
   localparam int              CHK_W   = DIV_W + $clog2(BLOCK_BYTES + 1);

   logic              stage0_ff, stage1_ff, done_ff;
   logic [DIV_W-1:0]  x0_ff, x1_ff, q1_ff, quo_ff;
   logic              rem_zero_ff;
   logic [PROD_W-1:0] prod;
   logic [CHK_W-1:0]  back;

   assign prod = PROD_W'(x0_ff) * PROD_W'(RECIP);
   assign back = CHK_W'(q1_ff) * CHK_W'(BLOCK_BYTES);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage0_ff <= 1'b0;
         stage1_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         stage0_ff <= div_req.start;
         stage1_ff <= stage0_ff;
         done_ff   <= stage1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         x0_ff <= div_req.dividend;
      end
      x1_ff       <= x0_ff;
      q1_ff       <= DIV_W'(prod >> SHIFT);
      quo_ff      <= q1_ff;
      rem_zero_ff <= (back == CHK_W'(x1_ff));
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.rem_zero = rem_zero_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

>>> rtl/core/block_heap_allocator.sv
// Block heap allocator, first fit with coalescing; one transaction at a time.
// Allocate walks the regions to the first that fits, then splits it and marks its blocks; free
// clears the region, merges a free right neighbour and steps back to the left neighbour's head;
// query walks the regions; a zero size or an address below the heap goes straight to the result.
// A stalled result is held; allocate and free wait on the divider; one table access a cycle.
// Reset (synchronous) leaves one free region covering the whole heap, ready at once.
module block_heap_allocator #(
   parameter int HEAP_BLOCKS = bha_pkg::HEAP_BLOCKS_DEF,
   parameter int BLOCK_BYTES = bha_pkg::BLOCK_BYTES_DEF,
   parameter int HEAP_BASE   = bha_pkg::HEAP_BASE_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bha_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bha_pkg::rsp_type rsp_data
);
   import bha_pkg::*;

   localparam int IDX_W = $clog2(HEAP_BLOCKS);
   localparam logic [WALK_W-1:0] NB = WALK_W'(HEAP_BLOCKS);

   state_type          state_ff, state_in;
   command_type        cmd_ff, cmd_in;
   status_type         status_ff, status_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [DIV_W-1:0]   need_ff, need_in;
   logic [WALK_W-1:0]  pos_ff, pos_in;
   logic [WALK_W-1:0]  cnt_ff, cnt_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [WALK_W-1:0]  total_ff, total_in;
   logic [WALK_W-1:0]  run_ff, run_in;
   logic [WALK_W-1:0]  best_ff, best_in;
   logic               first_ff, first_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               mem_rd_en, mem_wr_en;
   logic [WALK_W-1:0]  rd_pos, wr_pos;
   logic [ENTRY_W-1:0] mem_rd_data, mem_wr_data;
   logic [LEN_W-1:0]   rd_len;
   logic               rd_used;
   logic [WALK_W-1:0]  next_pos, run_sum, region_end, merged;
   logic [ADDR_W-1:0]  grant_addr;
   div_req_type        div_req;
   div_rsp_type        div_rsp;
   logic               req_take, rsp_take;

   function automatic logic [BYTES_W-1:0] to_bytes(input logic [WALK_W-1:0] blocks);
      int prod;
      prod = int'(blocks) * BLOCK_BYTES;
      return (prod > BYTES_MAX) ? BYTES_W'(BYTES_MAX) : BYTES_W'(prod);
   endfunction

   bha_mem #(
      .HEAP_BLOCKS(HEAP_BLOCKS)
   ) u_mem (
      .clock  (clock),
      .reset  (reset),
      .rd_en  (mem_rd_en),
      .rd_addr(rd_pos[IDX_W-1:0]),
      .rd_data(mem_rd_data),
      .wr_en  (mem_wr_en),
      .wr_addr(wr_pos[IDX_W-1:0]),
      .wr_data(mem_wr_data)
   );

   bha_div #(
      .BLOCK_BYTES(BLOCK_BYTES)
   ) u_div (
      .clock  (clock),
      .reset  (reset),
      .div_req(div_req),
      .div_rsp(div_rsp)
   );

   assign req_take   = req_valid && !req_stall;
   assign rsp_take   = rsp_valid_ff && !rsp_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign rd_len     = mem_rd_data[LEN_W-1:0];
   assign rd_used    = mem_rd_data[ENTRY_W-1];
   assign next_pos   = pos_ff + WALK_W'(rd_len);
   assign run_sum    = run_ff + WALK_W'(rd_len);
   assign region_end = pos_ff + WALK_W'(len_ff);
   assign merged     = WALK_W'(len_ff) + WALK_W'(rd_len);
   assign grant_addr = ADDR_W'(HEAP_BASE + int'(pos_ff) * BLOCK_BYTES);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      status_in    = status_ff;
      addr_in      = addr_ff;
      need_in      = need_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      len_in       = len_ff;
      total_in     = total_ff;
      run_in       = run_ff;
      best_in      = best_ff;
      first_in     = first_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_take;
      rsp_data_in  = rsp_data_ff;
      mem_rd_en    = 1'b0;
      mem_wr_en    = 1'b0;
      rd_pos       = pos_ff;
      wr_pos       = pos_ff;
      mem_wr_data  = '0;
      div_req      = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_data.command;
               addr_in   = req_data.release_address;
               status_in = ST_OK;
               pos_in    = '0;
               total_in  = '0;
               run_in    = '0;
               best_in   = '0;
               case (req_data.command)
                  CMD_ALLOC: begin
                     if (req_data.request_bytes == '0) begin
                        status_in = ST_ZERO_SIZE;
                        state_in  = S_RESP;
                     end else begin
                        div_req.start    = 1'b1;
                        div_req.dividend = DIV_W'(req_data.request_bytes)
                                         + DIV_W'(BLOCK_BYTES - 1);
                        state_in         = S_DIV_NEED;
                     end
                  end
                  CMD_FREE: begin
                     if (req_data.release_address < ADDR_W'(HEAP_BASE)) begin
                        status_in = ST_BAD_ADDR;
                        state_in  = S_RESP;
                     end else begin
                        div_req.start    = 1'b1;
                        div_req.dividend = DIV_W'(req_data.release_address);
                        state_in         = S_DIV_ALIGN;
                     end
                  end
                  CMD_QUERY: state_in = S_WALK_RD;
                  default:   state_in = S_RESP;
               endcase
            end
         end
         S_DIV_NEED: begin
            if (div_rsp.done) begin
               need_in  = div_rsp.quotient;
               state_in = S_WALK_RD;
            end
         end
         S_DIV_ALIGN: begin
            if (div_rsp.done) begin
               if (!div_rsp.rem_zero) begin
                  status_in = ST_BAD_ADDR;
                  state_in  = S_RESP;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = DIV_W'(addr_ff) - DIV_W'(HEAP_BASE);
                  state_in         = S_DIV_INDEX;
               end
            end
         end
         S_DIV_INDEX: begin
            if (div_rsp.done) begin
               if (div_rsp.quotient >= DIV_W'(HEAP_BLOCKS)) begin
                  status_in = ST_BAD_ADDR;
                  state_in  = S_RESP;
               end else begin
                  pos_in   = div_rsp.quotient[WALK_W-1:0];
                  state_in = S_FREE_RD;
               end
            end
         end
         S_WALK_RD: begin
            if (pos_ff >= NB) begin
               if (cmd_ff == CMD_ALLOC) begin
                  status_in = ST_NO_FIT;
               end
               state_in = S_RESP;
            end else begin
               mem_rd_en = 1'b1;
               state_in  = S_WALK_CHK;
            end
         end
         S_WALK_CHK: begin
            if (rd_len == '0) begin
               if (cmd_ff == CMD_ALLOC) begin
                  status_in = ST_NO_FIT;
               end
               state_in = S_RESP;
            end else if (cmd_ff == CMD_ALLOC) begin
               if (!rd_used && (DIV_W'(rd_len) >= need_ff)) begin
                  if (need_ff > DIV_W'(HEAP_BLOCKS)) begin
                     status_in = ST_NO_FIT;
                     state_in  = S_RESP;
                  end else begin
                     len_in   = rd_len;
                     state_in = S_SPLIT;
                  end
               end else begin
                  pos_in   = next_pos;
                  state_in = S_WALK_RD;
               end
            end else begin
               if (!rd_used) begin
                  total_in = total_ff + WALK_W'(rd_len);
                  run_in   = run_sum;
                  if (run_sum > best_ff) begin
                     best_in = run_sum;
                  end
               end else begin
                  run_in = '0;
               end
               pos_in   = next_pos;
               state_in = S_WALK_RD;
            end
         end
         S_SPLIT: begin
            // The tail of the chosen region becomes a free region of its own.
            wr_pos = pos_ff + WALK_W'(need_ff[LEN_W-1:0]);
            if ((len_ff > need_ff[LEN_W-1:0]) && (wr_pos < NB)) begin
               mem_wr_en   = 1'b1;
               mem_wr_data = ENTRY_W'(len_ff - need_ff[LEN_W-1:0]);
            end
            len_in   = need_ff[LEN_W-1:0];
            cnt_in   = pos_ff;
            state_in = S_MARK;
         end
         S_MARK: begin
            wr_pos = cnt_ff;
            if ((cnt_ff < region_end) && (cnt_ff < NB)) begin
               mem_wr_en   = 1'b1;
               mem_wr_data = {1'b1, (cnt_ff == pos_ff) ? len_ff : LEN_W'(0)};
               cnt_in      = cnt_ff + 1'b1;
            end else begin
               state_in = S_RESP;
            end
         end
         S_FREE_RD: begin
            mem_rd_en = 1'b1;
            state_in  = S_FREE_CHK;
         end
         S_FREE_CHK: begin
            if (!rd_used || (rd_len == '0)) begin
               status_in = ST_NOT_HEAD;
               state_in  = S_RESP;
            end else begin
               len_in   = rd_len;
               cnt_in   = pos_ff;
               state_in = S_CLEAR;
            end
         end
         S_CLEAR: begin
            wr_pos = cnt_ff;
            if ((cnt_ff < region_end) && (cnt_ff < NB)) begin
               mem_wr_en   = 1'b1;
               mem_wr_data = (cnt_ff == pos_ff) ? ENTRY_W'(len_ff) : '0;
               cnt_in      = cnt_ff + 1'b1;
            end else begin
               state_in = S_RIGHT_RD;
            end
         end
         S_RIGHT_RD: begin
            rd_pos = region_end;
            if (region_end < NB) begin
               mem_rd_en = 1'b1;
               state_in  = S_RIGHT_CHK;
            end else begin
               state_in = S_LEFT_RD;
            end
         end
         S_RIGHT_CHK: begin
            // A free right neighbour loses its head and joins this region.
            if (!rd_used) begin
               wr_pos      = region_end;
               mem_wr_en   = 1'b1;
               mem_wr_data = '0;
               len_in      = merged[LEN_W-1:0];
               state_in    = S_RIGHT_WR;
            end else begin
               state_in = S_LEFT_RD;
            end
         end
         S_RIGHT_WR: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = ENTRY_W'(len_ff);
            state_in    = S_LEFT_RD;
         end
         S_LEFT_RD: begin
            rd_pos = pos_ff - 1'b1;
            if (pos_ff == '0) begin
               state_in = S_RESP;
            end else begin
               mem_rd_en = 1'b1;
               cnt_in    = pos_ff - 1'b1;
               first_in  = 1'b1;
               state_in  = S_LEFT_CHK;
            end
         end
         S_LEFT_CHK: begin
            // Step back one entry a cycle until the head of the left region.
            rd_pos   = cnt_ff - 1'b1;
            wr_pos   = cnt_ff;
            first_in = 1'b0;
            if (first_ff && rd_used) begin
               state_in = S_RESP;
            end else if ((cnt_ff != '0) && (rd_len == '0)) begin
               mem_rd_en = 1'b1;
               cnt_in    = cnt_ff - 1'b1;
            end else if (rd_len == '0) begin
               state_in = S_RESP;
            end else begin
               mem_wr_en   = 1'b1;
               mem_wr_data = ENTRY_W'(rd_len + len_ff);
               state_in    = S_LEFT_WR;
            end
         end
         S_LEFT_WR: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = '0;
            state_in    = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.status = status_ff;
               rsp_data_in.granted_address =
                  ((cmd_ff == CMD_ALLOC) && (status_ff == ST_OK)) ? grant_addr : '0;
               rsp_data_in.total_free_bytes =
                  (cmd_ff == CMD_QUERY) ? to_bytes(total_ff) : '0;
               rsp_data_in.largest_free_bytes =
                  (cmd_ff == CMD_QUERY) ? to_bytes(best_ff) : '0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      status_ff   <= status_in;
      addr_ff     <= addr_in;
      need_ff     <= need_in;
      pos_ff      <= pos_in;
      cnt_ff      <= cnt_in;
      len_ff      <= len_in;
      total_ff    <= total_in;
      run_ff      <= run_in;
      best_ff     <= best_in;
      first_ff    <= first_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_single_port: assert property (@(posedge clock) disable iff (reset)
      !(mem_rd_en && mem_wr_en))
      else $error("table read and written in the same cycle");

   a_write_in_heap: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (wr_pos < NB))
      else $error("table write beyond the heap");

   a_div_expected: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_DIV_NEED || state_ff == S_DIV_ALIGN ||
                        state_ff == S_DIV_INDEX))
      else $error("divider finished outside a divide step");

   a_resp_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && (!rsp_valid_ff || !rsp_stall))
         |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("result transaction not presented");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff != S_IDLE || rsp_valid_ff))
      else $error("accepted transaction produced no result");

endmodule
